[rtl/crtd_pkg.sv]
// Package: widths, reset values, register indexes and helpers for the CRT coefficient decoder.
`timescale 1ns / 1ps
package crtd_pkg;

  localparam int PRIME_W    = 31;
  localparam int LOG_DEGREE = 16;
  localparam int IDX_W      = LOG_DEGREE;
  localparam int STRIDE_W   = 5;
  localparam int MANT_W     = 32;
  localparam int SHIFT_W    = 7;
  localparam int PROD_W     = 2 * PRIME_W;
  localparam int RED_STG    = PROD_W / 2;
  localparam int CENT_W     = 62;
  localparam int SCALE_W    = 64;
  localparam int SPLIT_W    = 32;
  localparam int SPROD_W    = PROD_W + MANT_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = ((2 * PRIME_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + CENT_W + SCALE_W + 7) / 8) * 8;

  localparam logic [PRIME_W-1:0]  PRIME_A_RST = PRIME_W'(2147483647);
  localparam logic [PRIME_W-1:0]  PRIME_B_RST = PRIME_W'(2147483629);
  localparam logic [MANT_W-1:0]   MANT_RST    = MANT_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME_A     = 3'd0,
    REG_PRIME_B     = 3'd1,
    REG_INV_B_MOD_A = 3'd2,
    REG_INV_A_MOD_B = 3'd3,
    REG_TWO_PRIMES  = 3'd4,
    REG_STRIDE_LOG2 = 3'd5,
    REG_SCALE_MANT  = 3'd6,
    REG_SCALE_SHIFT = 3'd7
  } cfg_reg_e;

  // Moduli below 2 act as 2.
  function automatic logic [PRIME_W-1:0] eff_prime(logic [PRIME_W-1:0] p);
    return (p < PRIME_W'(2)) ? PRIME_W'(2) : p;
  endfunction

endpackage

[rtl/crt_centered_coeff_decode.sv]
// Top level: CRT reconstruction, centered lift and fixed-point scaling of coefficients.
//
// Coefficient requests enter on s_axis: residue_a, residue_b and coeff_index in tdata.
// Only coefficients whose index is a multiple of 2^stride_log2 produce a result on
// m_axis: slot_index, centered_value and scaled_value in tdata. Others are dropped.
// Registers are written on the cfg channel (cfg_ready_o is always high); the user must
// write them only while no request is in flight, as the block does not enforce this.
// Throughput: one request per cycle while the pipeline is not frozen by a stall. From
// acceptance to m_axis_tvalid a request passes the entry and multiplier stages, the
// two-bit-per-stage remainder pipelines, then multiplier, add/compare, lift, scale, rounding and saturation stages.
// When the receiver stalls, the result holds in the output register; the pipeline keeps
// moving and accepting requests as long as its last stage is empty, then freezes as a
// whole with nothing lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the register reset
// values: prime_a 2^31-1, prime_b 2^31-19, two-prime mode, stride 0, scale 1.0.
`timescale 1ns / 1ps
module crt_centered_coeff_decode import crtd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // residue_a, residue_b, coeff_index, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot_index, centered_value, scaled_value, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Configuration registers
  logic [PRIME_W-1:0]  prime_a_q, prime_b_q, inv_b_mod_a_q, inv_a_mod_b_q;
  logic                two_primes_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [MANT_W-1:0]   mant_q;
  logic [SHIFT_W-1:0]  shift_q;
  cfg_reg_e            cfg_reg;

  assign cfg_ready_o = 1'b1;
  assign cfg_reg     = cfg_reg_e'(cfg_index_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_a_q     <= PRIME_A_RST;
      prime_b_q     <= PRIME_B_RST;
      inv_b_mod_a_q <= '0;
      inv_a_mod_b_q <= '0;
      two_primes_q  <= 1'b1;
      stride_q      <= '0;
      mant_q        <= MANT_RST;
      shift_q       <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_reg)
        REG_PRIME_A:     prime_a_q     <= cfg_data_i[PRIME_W-1:0];
        REG_PRIME_B:     prime_b_q     <= cfg_data_i[PRIME_W-1:0];
        REG_INV_B_MOD_A: inv_b_mod_a_q <= cfg_data_i[PRIME_W-1:0];
        REG_INV_A_MOD_B: inv_a_mod_b_q <= cfg_data_i[PRIME_W-1:0];
        REG_TWO_PRIMES:  two_primes_q  <= cfg_data_i[0];
        REG_STRIDE_LOG2: stride_q      <= cfg_data_i[STRIDE_W-1:0];
        REG_SCALE_MANT:  mant_q        <= cfg_data_i[MANT_W-1:0];
        REG_SCALE_SHIFT: shift_q       <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [PRIME_W-1:0] pa, pb;
  logic [PROD_W-1:0]  pp_q;
  logic [PROD_W-1:0]  modulus;

  assign pa      = eff_prime(prime_a_q);
  assign pb      = eff_prime(prime_b_q);
  assign modulus = two_primes_q ? pp_q : PROD_W'(pa);

  always_ff @(posedge clk_i) begin
    pp_q <= PROD_W'(pa) * PROD_W'(pb);
  end

  // Flow control
  logic adv, accept, out_load, i_vld_q;

  assign adv           = m_axis_tready || !m_axis_tvalid || !i_vld_q;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;
  assign out_load      = m_axis_tready || !m_axis_tvalid;

  // Entry: unpack, stride filter
  logic [PRIME_W-1:0]  in_ra, in_rb;
  logic [IDX_W-1:0]    in_idx, idx_mask;
  logic [STRIDE_W-1:0] st_sat;
  logic                keep;

  assign in_ra    = s_axis_tdata[PRIME_W-1:0];
  assign in_rb    = s_axis_tdata[2*PRIME_W-1:PRIME_W];
  assign in_idx   = s_axis_tdata[2*PRIME_W+IDX_W-1:2*PRIME_W];
  assign st_sat   = (stride_q > STRIDE_W'(LOG_DEGREE)) ? STRIDE_W'(LOG_DEGREE) : stride_q;
  assign idx_mask = ~({IDX_W{1'b1}} << st_sat);
  assign keep     = (in_idx & idx_mask) == '0;

  logic               e_vld_q, m_vld_q;
  logic [PRIME_W-1:0] e_ra_q, e_rb_q;
  logic [IDX_W-1:0]   e_slot_q, m_slot_q;
  logic [PROD_W-1:0]  m_da_q, m_db_q;

  logic               r_vld_q  [RED_STG];
  logic [IDX_W-1:0]   r_slot_q [RED_STG];
  logic [PRIME_W-1:0] a0, a1;

  logic               c_vld_q, a_vld_q, s_vld_q, n_vld_q, p_vld_q, x_vld_q, h_vld_q;
  logic [IDX_W-1:0]   c_slot_q, a_slot_q, s_slot_q, n_slot_q, p_slot_q, x_slot_q, h_slot_q,
                      i_slot_q;
  logic [PROD_W-1:0]  c_ta_q, c_tb_q;
  logic [PROD_W:0]    a_sum_q;
  logic [PROD_W-1:0]  s_val_q, n_mag_q;
  logic               n_neg_q, p_neg_q, x_neg_q, h_neg_q, i_neg_q;
  logic [CENT_W-1:0]  n_cent_q, p_cent_q, x_cent_q, h_cent_q, i_cent_q;
  logic [SPLIT_W+MANT_W-1:0]        p_lo_q;
  logic [PROD_W-SPLIT_W+MANT_W-1:0] p_hi_q;
  logic [SPROD_W-1:0] x_prod_q, h_quo_q, drop_mask;
  logic               h_drop_q;
  logic [SPROD_W:0]   i_quo_q;

  logic [PROD_W:0]    sum_red;
  logic               lift_neg;

  assign sum_red   = a_sum_q - {1'b0, modulus};
  assign lift_neg  = s_val_q > (modulus >> 1);
  assign drop_mask = ~({SPROD_W{1'b1}} << shift_q);

  crtd_mod_reduce u_red_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .dividend_i (m_da_q),
    .modulus_i  (pa),
    .rem_o      (a0)
  );

  crtd_mod_reduce u_red_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (adv),
    .dividend_i (m_db_q),
    .modulus_i  (pb),
    .rem_o      (a1)
  );

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
      m_vld_q <= 1'b0;
      for (int i = 0; i < RED_STG; i++) begin
        r_vld_q[i] <= 1'b0;
      end
      c_vld_q <= 1'b0;
      a_vld_q <= 1'b0;
      s_vld_q <= 1'b0;
      n_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
      x_vld_q <= 1'b0;
      h_vld_q <= 1'b0;
      i_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q    <= accept && keep;
      m_vld_q    <= e_vld_q;
      r_vld_q[0] <= m_vld_q;
      for (int i = 1; i < RED_STG; i++) begin
        r_vld_q[i] <= r_vld_q[i-1];
      end
      c_vld_q <= r_vld_q[RED_STG-1];
      a_vld_q <= c_vld_q;
      s_vld_q <= a_vld_q;
      n_vld_q <= s_vld_q;
      p_vld_q <= n_vld_q;
      x_vld_q <= p_vld_q;
      h_vld_q <= x_vld_q;
      i_vld_q <= h_vld_q;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_ra_q   <= in_ra;
      e_rb_q   <= in_rb;
      e_slot_q <= in_idx >> st_sat;

      m_da_q   <= two_primes_q ? PROD_W'(e_ra_q) * PROD_W'(inv_b_mod_a_q) : PROD_W'(e_ra_q);
      m_db_q   <= PROD_W'(e_rb_q) * PROD_W'(inv_a_mod_b_q);
      m_slot_q <= e_slot_q;

      r_slot_q[0] <= m_slot_q;
      for (int i = 1; i < RED_STG; i++) begin
        r_slot_q[i] <= r_slot_q[i-1];
      end

      c_ta_q   <= two_primes_q ? PROD_W'(a0) * PROD_W'(pb) : PROD_W'(a0);
      c_tb_q   <= two_primes_q ? PROD_W'(a1) * PROD_W'(pa) : '0;
      c_slot_q <= r_slot_q[RED_STG-1];

      a_sum_q  <= {1'b0, c_ta_q} + {1'b0, c_tb_q};
      a_slot_q <= c_slot_q;

      s_val_q  <= sum_red[PROD_W] ? a_sum_q[PROD_W-1:0] : sum_red[PROD_W-1:0];
      s_slot_q <= a_slot_q;

      n_neg_q  <= lift_neg;
      n_mag_q  <= lift_neg ? modulus - s_val_q : s_val_q;
      n_cent_q <= lift_neg ? CENT_W'(s_val_q - modulus) : CENT_W'(s_val_q);
      n_slot_q <= s_slot_q;

      p_lo_q   <= (SPLIT_W+MANT_W)'(n_mag_q[SPLIT_W-1:0]) * (SPLIT_W+MANT_W)'(mant_q);
      p_hi_q   <= (PROD_W-SPLIT_W+MANT_W)'(n_mag_q[PROD_W-1:SPLIT_W]) *
                  (PROD_W-SPLIT_W+MANT_W)'(mant_q);
      p_neg_q  <= n_neg_q;
      p_cent_q <= n_cent_q;
      p_slot_q <= n_slot_q;

      x_prod_q <= SPROD_W'(p_lo_q) + (SPROD_W'(p_hi_q) << SPLIT_W);
      x_neg_q  <= p_neg_q;
      x_cent_q <= p_cent_q;
      x_slot_q <= p_slot_q;

      h_quo_q  <= x_prod_q >> shift_q;
      h_drop_q <= (x_prod_q & drop_mask) != '0;
      h_neg_q  <= x_neg_q;
      h_cent_q <= x_cent_q;
      h_slot_q <= x_slot_q;

      // floor of a negative quotient rounds the magnitude up
      i_quo_q  <= {1'b0, h_quo_q} + (SPROD_W+1)'(h_neg_q && h_drop_q);
      i_neg_q  <= h_neg_q;
      i_cent_q <= h_cent_q;
      i_slot_q <= h_slot_q;
    end
  end

  // Saturation and output register
  logic                ovf;
  logic [SCALE_W-1:0]  scaled;

  assign ovf = i_quo_q[SPROD_W:SCALE_W-1] != '0;

  always_comb begin
    if (!i_neg_q) begin
      scaled = ovf ? {1'b0, {(SCALE_W-1){1'b1}}} : i_quo_q[SCALE_W-1:0];
    end else begin
      scaled = ovf ? {1'b1, {(SCALE_W-1){1'b0}}} : -i_quo_q[SCALE_W-1:0];
    end
  end

  logic                out_vld_q;
  logic [IDX_W-1:0]    out_slot_q;
  logic [CENT_W-1:0]   out_cent_q;
  logic [SCALE_W-1:0]  out_scaled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= i_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_slot_q   <= i_slot_q;
      out_cent_q   <= i_cent_q;
      out_scaled_q <= scaled;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_scaled_q, out_cent_q, out_slot_q});

endmodule

[rtl/crtd_mod_reduce.sv]
// Pipelined remainder unit: PROD_W-bit dividend modulo a PRIME_W-bit modulus, two bits per stage.
`timescale 1ns / 1ps
module crtd_mod_reduce import crtd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [PROD_W-1:0]  dividend_i,
  input  logic [PRIME_W-1:0] modulus_i,
  output logic [PRIME_W-1:0] rem_o
);

  logic [PRIME_W-1:0] rem_q [RED_STG];
  logic [PROD_W-1:0]  div_q [RED_STG];
  logic [PRIME_W-1:0] rem_d [RED_STG];
  logic [PROD_W-1:0]  div_d [RED_STG];

  // One restoring step; r stays below m.
  function automatic logic [PRIME_W-1:0] rstep(logic [PRIME_W-1:0] r, logic b,
                                               logic [PRIME_W-1:0] m);
    logic [PRIME_W:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[PRIME_W-1:0];
  endfunction

  always_comb begin
    rem_d[0] = rstep(rstep('0, dividend_i[PROD_W-1], modulus_i),
                     dividend_i[PROD_W-2], modulus_i);
    div_d[0] = dividend_i << 2;
    for (int i = 1; i < RED_STG; i++) begin
      rem_d[i] = rstep(rstep(rem_q[i-1], div_q[i-1][PROD_W-1], modulus_i),
                       div_q[i-1][PROD_W-2], modulus_i);
      div_d[i] = div_q[i-1] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RED_STG; i++) begin
        rem_q[i] <= '0;
      end
    end else if (en_i) begin
      for (int i = 0; i < RED_STG; i++) begin
        rem_q[i] <= rem_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < RED_STG; i++) begin
        div_q[i] <= div_d[i];
      end
    end
  end

  assign rem_o = rem_q[RED_STG-1];

endmodule
